// File: hw/rtl/ptts_pkg.sv
package ptts_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int SLOT_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W      = $clog2(MAX_TASKS + 1);
    localparam int DATA_W     = 16;
    localparam int SLOT_OUT_W = 4;

    localparam logic [DATA_W-1:0] PEND_MAX = '1;

    typedef enum logic [2:0] {
        ACT_TICK     = 3'd0,
        ACT_CREATE   = 3'd1,
        ACT_DELETE   = 3'd2,
        ACT_DISPATCH = 3'd3,
        ACT_START    = 3'd4,
        ACT_STOP     = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_NOTASK  = 3'd2,
        ST_RUN     = 3'd3,
        ST_REFUSED = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_DRD,
        S_DCHK,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [2:0]        action;
        logic [3:0]        task_slot;
        logic [DATA_W-1:0] first_delay;
        logic [DATA_W-1:0] period;
    } t_in_item;

    typedef struct packed {
        logic [2:0]            status;
        logic [SLOT_OUT_W-1:0] slot_out;
        logic                  last;
        logic                  running;
    } t_out_item;

    typedef struct packed {
        logic [DATA_W-1:0] countdown;
        logic [DATA_W-1:0] reload_period;
        logic [DATA_W-1:0] pending_runs;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        t_entry            wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_ram_req;

endpackage

// File: hw/rtl/periodic_task_tick_scheduler.sv
// Periodic task tick scheduler with a table of MAX_TASKS task slots.
// Input items arrive on i_in_valid / o_in_stall / i_in_item and carry an action:
// tick, create, delete, dispatch, start or stop. Result items leave on
// o_out_valid / i_out_stall / o_out_item. Each action gives one result item,
// except dispatch, which gives one run item per task with pending runs,
// lowest slot first, and then a closing item with last set.
// Create, delete, start, stop and an idle tick go from accept through S_FIN
// to the output register. A running tick walks the task memory as a read,
// update and write-back pipeline over every slot. Dispatch visits each slot
// in S_DRD, checks each used slot's entry in S_DCHK and closes in S_FIN. The
// task memory port handles one entry per cycle.
// A new item is accepted only after the previous one has placed its last result
// in the output register, which may still be waiting for the receiver.
// A valid output item holds while i_out_stall is high; no new result replaces it.
// Synchronous reset frees every slot and clears the running flag; the
// task memory itself is not cleared, since every slot is written at create.
module periodic_task_tick_scheduler import ptts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_ram_req ram_req;
    t_entry   ram_rdata;

    ptts_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    ptts_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    a_no_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
        else $error("task memory read and write hit the same entry");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.last == (o_out_item.status != ST_RUN)))
        else $error("last flag does not match item kind");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != ST_RUN && o_out_item.status != ST_OK)
        |-> (o_out_item.slot_out == '0))
        else $error("error result carries a slot");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer accepted an item without going busy");

endmodule

// File: hw/rtl/ptts_ram.sv
module ptts_ram import ptts_pkg::*; (
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_entry   o_rdata
);

    t_entry r_mem [MAX_TASKS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/ptts_seq.sv
module ptts_seq import ptts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    output t_ram_req  o_ram_req,
    input  t_entry    i_ram_rdata
);

    t_state                 r_state, n_state;
    logic [MAX_TASKS-1:0]   r_used, n_used;
    logic                   r_run_en, n_run_en;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic                   r_wb_vld, n_wb_vld;
    logic [SLOT_W-1:0]      r_wb_idx, n_wb_idx;
    t_status                r_fin_status, n_fin_status;
    logic [SLOT_OUT_W-1:0]  r_fin_slot, n_fin_slot;
    logic                   r_out_vld, n_out_vld;
    t_out_item              r_out, n_out;

    logic                   out_free;
    logic                   in_acc;
    logic [SLOT_W-1:0]      idx_s;
    logic                   idx_end;
    logic                   free_found;
    logic [SLOT_W-1:0]      free_idx;
    logic                   del_ok;
    t_entry                 tick_entry;
    t_ram_req               ram_req;

    assign out_free = !r_out_vld || !i_out_stall;
    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign idx_s    = r_idx[SLOT_W-1:0];
    assign idx_end  = (r_idx == CNT_W'(MAX_TASKS));
    assign del_ok   = (int'(i_in_item.task_slot) < MAX_TASKS)
                      && r_used[SLOT_W'(i_in_item.task_slot)];

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        tick_entry = i_ram_rdata;
        if (i_ram_rdata.countdown != '0) begin
            tick_entry.countdown = i_ram_rdata.countdown - 1'b1;
        end else begin
            if (i_ram_rdata.pending_runs != PEND_MAX) begin
                tick_entry.pending_runs = i_ram_rdata.pending_runs + 1'b1;
            end
            if (i_ram_rdata.reload_period != '0) begin
                tick_entry.countdown = i_ram_rdata.reload_period - 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_item.action)
                        ACT_TICK:     n_state = r_run_en ? S_TICK : S_FIN;
                        ACT_DISPATCH: n_state = S_DRD;
                        default:      n_state = S_FIN;
                    endcase
                end
            end
            S_TICK: begin
                if (idx_end && !r_wb_vld) begin
                    n_state = S_FIN;
                end
            end
            S_DRD: begin
                if (idx_end) begin
                    n_state = S_FIN;
                end else if (r_used[idx_s]) begin
                    n_state = S_DCHK;
                end
            end
            S_DCHK: begin
                if (i_ram_rdata.pending_runs == '0 || out_free) begin
                    n_state = S_DRD;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_used       = r_used;
        n_run_en     = r_run_en;
        n_idx        = r_idx;
        n_wb_vld     = 1'b0;
        n_wb_idx     = r_wb_idx;
        n_fin_status = r_fin_status;
        n_fin_slot   = r_fin_slot;
        n_out_vld    = r_out_vld && i_out_stall;
        n_out        = r_out;
        ram_req      = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx        = '0;
                    n_fin_status = ST_OK;
                    n_fin_slot   = '0;
                    case (i_in_item.action)
                        ACT_CREATE: begin
                            if (free_found) begin
                                n_used[free_idx]            = 1'b1;
                                ram_req.we                  = 1'b1;
                                ram_req.waddr               = free_idx;
                                ram_req.wdata.countdown     = i_in_item.first_delay;
                                ram_req.wdata.reload_period = i_in_item.period;
                                ram_req.wdata.pending_runs  = '0;
                                n_fin_slot = SLOT_OUT_W'(free_idx);
                            end else begin
                                n_fin_status = ST_FULL;
                            end
                        end
                        ACT_DELETE: begin
                            if (del_ok) begin
                                n_used[SLOT_W'(i_in_item.task_slot)] = 1'b0;
                            end else begin
                                n_fin_status = ST_NOTASK;
                            end
                        end
                        ACT_START: begin
                            if (|r_used) begin
                                n_run_en = 1'b1;
                            end else begin
                                n_fin_status = ST_REFUSED;
                            end
                        end
                        ACT_STOP: begin
                            n_run_en = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TICK: begin
                if (!idx_end) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_s;
                    n_wb_vld      = 1'b1;
                    n_wb_idx      = idx_s;
                    n_idx         = r_idx + 1'b1;
                end
                if (r_wb_vld && r_used[r_wb_idx]) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = r_wb_idx;
                    ram_req.wdata = tick_entry;
                end
            end
            S_DRD: begin
                if (!idx_end) begin
                    if (r_used[idx_s]) begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = idx_s;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_DCHK: begin
                if (i_ram_rdata.pending_runs == '0) begin
                    n_idx = r_idx + 1'b1;
                end else if (out_free) begin
                    ram_req.we                 = 1'b1;
                    ram_req.waddr              = idx_s;
                    ram_req.wdata              = i_ram_rdata;
                    ram_req.wdata.pending_runs = i_ram_rdata.pending_runs - 1'b1;
                    if (i_ram_rdata.reload_period == '0) begin
                        n_used[idx_s] = 1'b0;
                    end
                    n_out_vld        = 1'b1;
                    n_out.status     = ST_RUN;
                    n_out.slot_out   = SLOT_OUT_W'(idx_s);
                    n_out.last       = 1'b0;
                    n_out.running    = r_run_en;
                    n_idx            = r_idx + 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_vld      = 1'b1;
                    n_out.status   = r_fin_status;
                    n_out.slot_out = r_fin_slot;
                    n_out.last     = 1'b1;
                    n_out.running  = r_run_en;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_run_en  <= 1'b0;
            r_wb_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_run_en  <= n_run_en;
            r_wb_vld  <= n_wb_vld;
            r_out_vld <= n_out_vld;
        end
        r_idx        <= n_idx;
        r_wb_idx     <= n_wb_idx;
        r_fin_status <= n_fin_status;
        r_fin_slot   <= n_fin_slot;
        r_out        <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;
    assign o_ram_req   = ram_req;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ptts_pkg::*;

    localparam int          CYCLE_LIMIT   = 400_000;
    localparam int          SETTLE_CYCLES = 60;
    localparam int          MAX_IDLE      = 18;
    localparam logic [2:0]  ACT_SPARE_LO  = 3'd6;
    localparam logic [2:0]  ACT_SPARE_HI  = 3'd7;
    localparam logic [2:0]  ACTION_ORDER [6] = '{ACT_TICK, ACT_CREATE, ACT_DELETE,
                                                 ACT_DISPATCH, ACT_START, ACT_STOP};
    localparam int          ACTION_MIX [3][6] = '{'{35, 53, 63, 83, 93, 97},
                                                  '{20, 65, 70, 85, 95, 98},
                                                  '{20, 25, 65, 80, 95, 98}};

    class task_table_mirror;
        bit                used      [MAX_TASKS];
        bit [DATA_W-1:0]   countdown [MAX_TASKS];
        bit [DATA_W-1:0]   reload    [MAX_TASKS];
        bit [DATA_W-1:0]   pending   [MAX_TASKS];
        bit                enabled;
        t_out_item         awaited_results [$];
        int                errors;

        function void push_result(logic [2:0] status, int slot, bit last);
            t_out_item r;
            r.status   = status;
            r.slot_out = SLOT_OUT_W'(slot);
            r.last     = last;
            r.running  = enabled;
            awaited_results.push_back(r);
        endfunction

        function void note_request(t_in_item req);
            bit placed;
            bit any;
            int idx;
            placed = 1'b0;
            any    = 1'b0;
            idx    = int'(req.task_slot);
            case (req.action)
                ACT_TICK: begin
                    if (enabled) begin
                        for (int i = 0; i < MAX_TASKS; i++) begin
                            if (used[i]) begin
                                if (countdown[i] != 0) begin
                                    countdown[i] = countdown[i] - 1'b1;
                                end else begin
                                    if (pending[i] != PEND_MAX) pending[i] = pending[i] + 1'b1;
                                    if (reload[i] != 0) countdown[i] = reload[i] - 1'b1;
                                end
                            end
                        end
                    end
                    push_result(ST_OK, 0, 1'b1);
                end
                ACT_CREATE: begin
                    for (int i = 0; i < MAX_TASKS; i++) begin
                        if (!placed && !used[i]) begin
                            placed       = 1'b1;
                            used[i]      = 1'b1;
                            countdown[i] = req.first_delay;
                            reload[i]    = req.period;
                            pending[i]   = '0;
                            push_result(ST_OK, i, 1'b1);
                        end
                    end
                    if (!placed) push_result(ST_FULL, 0, 1'b1);
                end
                ACT_DELETE: begin
                    if (idx < MAX_TASKS && used[idx]) begin
                        used[idx] = 1'b0;
                        push_result(ST_OK, 0, 1'b1);
                    end else begin
                        push_result(ST_NOTASK, 0, 1'b1);
                    end
                end
                ACT_DISPATCH: begin
                    for (int i = 0; i < MAX_TASKS; i++) begin
                        if (used[i] && pending[i] != 0) begin
                            pending[i] = pending[i] - 1'b1;
                            if (reload[i] == 0) used[i] = 1'b0;
                            push_result(ST_RUN, i, 1'b0);
                        end
                    end
                    push_result(ST_OK, 0, 1'b1);
                end
                ACT_START: begin
                    for (int i = 0; i < MAX_TASKS; i++) any |= used[i];
                    if (any) begin
                        enabled = 1'b1;
                        push_result(ST_OK, 0, 1'b1);
                    end else begin
                        push_result(ST_REFUSED, 0, 1'b1);
                    end
                end
                ACT_STOP: begin
                    enabled = 1'b0;
                    push_result(ST_OK, 0, 1'b1);
                end
                default: begin
                    push_result(ST_OK, 0, 1'b1);
                end
            endcase
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual status %0d slot %0d last %0d running %0d",
                         $time, got.status, got.slot_out, got.last, got.running);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("slot_out", want.slot_out, got.slot_out);
            compare_field("last", want.last, got.last);
            compare_field("running", want.running, got.running);
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in_item   = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;

    int          in_gap_max     = 0;
    int          out_stall_max  = 0;
    int unsigned cycle_count    = 0;

    task_table_mirror mirror = new();

    periodic_task_tick_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int small_or_wide(int narrow_hi);
        return ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 65535))
                                           : int'($urandom_range(0, narrow_hi));
    endfunction

    function automatic logic [2:0] pick_action(int profile);
        int roll = $urandom_range(0, 99);
        for (int k = 0; k < 6; k++) begin
            if (roll < ACTION_MIX[profile][k]) return ACTION_ORDER[k];
        end
        return ($urandom_range(0, 1) != 0) ? ACT_SPARE_LO : ACT_SPARE_HI;
    endfunction

    task automatic issue_request(input logic [2:0] act, input int slot, input int first,
                                 input int per);
        t_in_item req;
        int       gap;
        req.action      = act;
        req.task_slot   = 4'(slot);
        req.first_delay = DATA_W'(first);
        req.period      = DATA_W'(per);
        gap = (in_gap_max == 0) ? 0 : int'($urandom_range(0, in_gap_max));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (o_in_stall);
        mirror.note_request(req);
    endtask

    initial begin : result_sink
        int hold;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            hold = (out_stall_max == 0) ? 0 : int'($urandom_range(0, out_stall_max));
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            mirror.check_result(o_out_item);
        end
    end

    initial begin : stimulus
        logic [2:0] act;
        int         slot;
        int         profile;
        int         used_slots [$];

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        in_gap_max    = MAX_IDLE;
        out_stall_max = MAX_IDLE;
        issue_request(ACT_START, 0, 0, 0);
        issue_request(ACT_TICK, 0, 0, 0);
        issue_request(ACT_DISPATCH, 0, 0, 0);
        issue_request(ACT_DELETE, 15, 0, 0);
        issue_request(ACT_STOP, 0, 0, 0);
        issue_request(ACT_CREATE, 0, 0, 0);
        issue_request(ACT_CREATE, 15, 65535, 65535);
        issue_request(ACT_CREATE, 0, 1, 1);
        issue_request(ACT_CREATE, 0, 2, 3);
        issue_request(ACT_TICK, 0, 0, 0);
        issue_request(ACT_START, 0, 0, 0);
        repeat (3) issue_request(ACT_TICK, 0, 0, 0);
        issue_request(ACT_DISPATCH, 0, 0, 0);
        issue_request(ACT_DELETE, 1, 0, 0);
        issue_request(ACT_DELETE, 1, 0, 0);
        issue_request(ACT_SPARE_LO, 0, 0, 0);
        issue_request(ACT_SPARE_HI, 15, 65535, 65535);
        issue_request(ACT_STOP, 0, 0, 0);
        issue_request(ACT_TICK, 0, 0, 0);
        issue_request(ACT_DISPATCH, 0, 0, 0);
        issue_request(ACT_CREATE, 0, 0, 0);
        issue_request(ACT_START, 0, 0, 0);

        // Each block of items leans toward filling the table, draining it, or neither.
        for (int c = 0; c < 8; c++) begin
            profile       = $urandom_range(0, 2);
            in_gap_max    = ($urandom_range(0, 1) != 0) ? MAX_IDLE : 0;
            out_stall_max = ($urandom_range(0, 1) != 0) ? MAX_IDLE : 0;
            for (int k = 0; k < 20; k++) begin
                act  = pick_action(profile);
                slot = $urandom_range(0, 15);
                if (act == ACT_DELETE && $urandom_range(0, 3) != 0) begin
                    used_slots = {};
                    for (int i = 0; i < MAX_TASKS; i++) begin
                        if (mirror.used[i]) used_slots.push_back(i);
                    end
                    if (used_slots.size() > 0) begin
                        slot = used_slots[$urandom_range(0, used_slots.size() - 1)];
                    end
                end
                issue_request(act, slot, small_or_wide(4), small_or_wide(5));
            end
        end
        i_in_valid <= 1'b0;

        while (mirror.awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.awaited_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// File: files.f
hw/rtl/ptts_pkg.sv
hw/rtl/ptts_ram.sv
hw/rtl/ptts_seq.sv
hw/rtl/periodic_task_tick_scheduler.sv
tb/testbench.sv
